// ===== sv/kpd_pkg.sv =====
// Package for the key packet deframer: codes, header constants, result type and
// sequencer state types. No dependencies; compiled before every other file.

package kpd_pkg;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_BAD_LENGTH   = 2'd1;
	localparam logic [1:0] ST_BAD_CHECKSUM = 2'd2;
	localparam logic [1:0] ST_BAD_TYPE     = 2'd3;

	localparam logic [7:0] START_MARK   = 8'hAA;
	localparam logic [7:0] DEV_LEFT     = 8'h01;
	localparam logic [7:0] DEV_RIGHT    = 8'h02;
	localparam logic [7:0] TYPE_KEY     = 8'h01;
	localparam logic [7:0] TYPE_BALL    = 8'h02;
	localparam logic [7:0] TYPE_SYSTEM  = 8'h03;
	localparam logic [7:0] TYPE_BATTERY = 8'h04;

	localparam int HDR_BYTES  = 5;
	localparam int BALL_BYTES = 4;
	localparam int CNT_W      = 9;
	localparam int COPY_W     = 6;
	localparam int COL_W      = 7;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MRD,
		S_RD,
		S_WR,
		S_EMIT
	} kpd_state_t;

	typedef enum logic {
		JOB_COPY,
		JOB_BALL
	} kpd_job_t;

	typedef struct packed {
		logic               result_kind;
		logic [1:0]         frame_status;
		logic [7:0]         source_device;
		logic [7:0]         frame_type;
		logic [7:0]         frame_length;
		logic               matrix_updated;
		logic               motion_valid;
		logic signed [15:0] move_x;
		logic signed [15:0] move_y;
		logic [7:0]         read_data;
	} kpd_result_t;

endpackage

// ===== sv/kpd_req_if.sv =====
// Input channel of the key packet deframer: valid, ready and one input item.
// Depends on nothing; compiled after kpd_pkg.

interface kpd_req_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;
	logic [3:0] read_index;

	modport source (output valid, opcode, rx_byte, read_index, input ready);
	modport sink (input valid, opcode, rx_byte, read_index, output ready);
endinterface

// ===== sv/kpd_rsp_if.sv =====
// Result channel of the key packet deframer: valid, ready and one result item.
// Depends on nothing; compiled after kpd_pkg.

interface kpd_rsp_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [1:0]         frame_status;
	logic [7:0]         source_device;
	logic [7:0]         frame_type;
	logic [7:0]         frame_length;
	logic               matrix_updated;
	logic               motion_valid;
	logic signed [15:0] move_x;
	logic signed [15:0] move_y;
	logic [7:0]         read_data;

	modport source (output valid, result_kind, frame_status, source_device, frame_type,
		frame_length, matrix_updated, motion_valid, move_x, move_y, read_data,
		input ready);
	modport sink (input valid, result_kind, frame_status, source_device, frame_type,
		frame_length, matrix_updated, motion_valid, move_x, move_y, read_data,
		output ready);
endinterface

// ===== sv/key_packet_deframer_unit.sv =====
// Key packet deframer top level: frame parser, payload memory, key matrix memory
// and the copy sequencer. Depends on kpd_pkg, kpd_req_if and kpd_rsp_if.
//
//   Channel  Interface   Role    Item
//   req      kpd_req_if  sink    radio byte or key matrix column read
//   rsp      kpd_rsp_if  source  frame status or key matrix column data
//
// A byte that gives no result leaves the block ready; a column read passes the
// matrix read state. A closing checksum byte adds a read and a write per copied
// key column or trackball byte, all through the one payload memory port.
// A held result stalls the block only when the next result is ready to leave.
// Reset clears the parser and the matrix valid bits at once; no clearing pass.

module key_packet_deframer_unit
	import kpd_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = 32,
	parameter int LEFT_COLUMNS      = 8,
	parameter int RIGHT_COLUMNS     = 8,
	parameter int MATRIX_COLUMNS    = 16
) (
	input  logic clk,
	input  logic arst_n,
	kpd_req_if.sink   req,
	kpd_rsp_if.source rsp
);

	localparam int PAY_AW = $clog2(MAX_PAYLOAD_BYTES);
	localparam int MAT_AW = $clog2(MATRIX_COLUMNS);

	kpd_state_t state_q, state_d;
	kpd_job_t   job_q, job_d;

	logic              in_frame_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [7:0]        xor_q;
	logic [7:0]        dev_q;
	logic [7:0]        type_q;
	logic [7:0]        len_q;
	logic [COPY_W-1:0] i_q;
	logic [COPY_W-1:0] n_q, n_d;
	logic [COL_W-1:0]  base_q, base_d;
	logic              out_valid_q;

	logic [7:0] pay_mem [MAX_PAYLOAD_BYTES];
	logic [7:0] mat_mem [MATRIX_COLUMNS];
	logic [MATRIX_COLUMNS-1:0] mat_vld_q;
	logic [7:0] pay_rd_q;
	logic [7:0] mat_rd_q;
	logic       mat_hit_q;

	kpd_result_t res_q, fin_res, out_q;
	kpd_result_t rd_res, out_d;
	logic [31:0] motion_q;

	logic              acc, acc_byte, acc_read;
	logic              hunt_start, hdr_byte, over, pay_byte, chk_byte;
	logic              xor_ok, known_half, fin_copy, fin_ball;
	logic [CNT_W-1:0]  cnt_inc, pay_ptr, frame_end;
	logic [CNT_W-1:0]  half_cols, copy_len;
	logic [COL_W-1:0]  col;
	logic [7:0]        i_ext, idx_ext;
	logic [MAT_AW-1:0] rd_addr, wr_addr;
	logic              rd_in_range, wr_en, load_out, step_last;

	always_comb begin
		acc      = req.valid && req.ready;
		acc_read = acc && (req.opcode == OP_READ);
		acc_byte = acc && (req.opcode == OP_BYTE);

		cnt_inc   = cnt_q + CNT_W'(1);
		pay_ptr   = cnt_q - CNT_W'(HDR_BYTES);
		frame_end = CNT_W'(HDR_BYTES) + {1'b0, len_q};

		hunt_start = !in_frame_q && (req.rx_byte == START_MARK);
		hdr_byte   = in_frame_q && (cnt_q < CNT_W'(HDR_BYTES));
		over       = hdr_byte && (cnt_q == CNT_W'(HDR_BYTES - 1))
			&& ({1'b0, req.rx_byte} > CNT_W'(MAX_PAYLOAD_BYTES));
		pay_byte   = in_frame_q && !hdr_byte && (cnt_q < frame_end);
		chk_byte   = in_frame_q && !hdr_byte && !pay_byte;

		xor_ok     = (xor_q == req.rx_byte);
		known_half = (dev_q == DEV_LEFT) || (dev_q == DEV_RIGHT);
		half_cols  = (dev_q == DEV_LEFT) ? CNT_W'(LEFT_COLUMNS) : CNT_W'(RIGHT_COLUMNS);
		copy_len   = ({1'b0, len_q} < half_cols) ? {1'b0, len_q} : half_cols;
		base_d     = (dev_q == DEV_LEFT) ? COL_W'(0) : COL_W'(LEFT_COLUMNS);
		fin_copy   = xor_ok && (type_q == TYPE_KEY) && known_half;
		fin_ball   = xor_ok && (type_q == TYPE_BALL) && (len_q >= 8'(BALL_BYTES));

		fin_res                = '0;
		fin_res.result_kind    = KIND_FRAME;
		fin_res.source_device  = dev_q;
		fin_res.frame_type     = type_q;
		fin_res.frame_length   = over ? req.rx_byte : len_q;
		fin_res.matrix_updated = !over && fin_copy;
		fin_res.motion_valid   = !over && fin_ball;
		if (over) begin
			fin_res.frame_status = ST_BAD_LENGTH;
		end else if (!xor_ok) begin
			fin_res.frame_status = ST_BAD_CHECKSUM;
		end else if ((type_q == TYPE_KEY) || (type_q == TYPE_BALL)
			|| (type_q == TYPE_SYSTEM) || (type_q == TYPE_BATTERY)) begin
			fin_res.frame_status = ST_OK;
		end else begin
			fin_res.frame_status = ST_BAD_TYPE;
		end

		rd_res             = '0;
		rd_res.result_kind = KIND_READ;

		out_d        = res_q;
		out_d.move_x = motion_q[15:0];
		out_d.move_y = motion_q[31:16];

		i_ext       = 8'(i_q);
		idx_ext     = 8'(req.read_index);
		rd_addr     = idx_ext[MAT_AW-1:0];
		rd_in_range = COL_W'(req.read_index) < COL_W'(MATRIX_COLUMNS);
		col         = base_q + COL_W'(i_q);
		wr_addr     = col[MAT_AW-1:0];
		wr_en       = (state_q == S_WR) && (job_q == JOB_COPY)
			&& (col < COL_W'(MATRIX_COLUMNS));
		step_last   = (i_q + COPY_W'(1)) == n_q;
		load_out    = (state_q == S_EMIT) && (!out_valid_q || rsp.ready);
	end

	always_comb begin
		state_d = state_q;
		job_d   = job_q;
		n_d     = n_q;
		case (state_q)
			S_IDLE: begin
				if (acc_read) begin
					state_d = S_MRD;
				end else if (acc_byte && over) begin
					state_d = S_EMIT;
				end else if (acc_byte && chk_byte) begin
					if (fin_copy && (copy_len != '0)) begin
						state_d = S_RD;
						job_d   = JOB_COPY;
						n_d     = COPY_W'(copy_len);
					end else if (fin_ball) begin
						state_d = S_RD;
						job_d   = JOB_BALL;
						n_d     = COPY_W'(BALL_BYTES);
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_MRD: state_d = S_EMIT;
			S_RD:  state_d = S_WR;
			S_WR:  state_d = step_last ? S_EMIT : S_RD;
			S_EMIT: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_q       <= JOB_COPY;
			in_frame_q  <= 1'b0;
			cnt_q       <= '0;
			xor_q       <= '0;
			dev_q       <= '0;
			type_q      <= '0;
			len_q       <= '0;
			i_q         <= '0;
			n_q         <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
			mat_vld_q   <= '0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
			n_q     <= n_d;
			if (acc_byte) begin
				if (hunt_start) begin
					in_frame_q <= 1'b1;
					cnt_q      <= CNT_W'(1);
					xor_q      <= START_MARK;
				end else if (hdr_byte) begin
					if (cnt_q == CNT_W'(1)) begin
						dev_q <= req.rx_byte;
					end
					if (cnt_q == CNT_W'(3)) begin
						type_q <= req.rx_byte;
					end
					if (cnt_q == CNT_W'(4)) begin
						len_q <= req.rx_byte;
					end
					xor_q <= xor_q ^ req.rx_byte;
					if (over) begin
						in_frame_q <= 1'b0;
						cnt_q      <= '0;
					end else begin
						cnt_q <= cnt_inc;
					end
				end else if (pay_byte) begin
					xor_q <= xor_q ^ req.rx_byte;
					cnt_q <= cnt_inc;
				end else if (chk_byte) begin
					in_frame_q <= 1'b0;
					cnt_q      <= '0;
					i_q        <= '0;
					base_q     <= base_d;
				end
			end
			if (state_q == S_WR) begin
				i_q <= i_q + COPY_W'(1);
			end
			if (wr_en) begin
				mat_vld_q[wr_addr] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_byte && pay_byte) begin
			pay_mem[pay_ptr[PAY_AW-1:0]] <= req.rx_byte;
		end
		pay_rd_q <= pay_mem[i_ext[PAY_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mat_mem[wr_addr] <= pay_rd_q;
		end
		mat_rd_q  <= mat_mem[rd_addr];
		mat_hit_q <= rd_in_range && mat_vld_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (acc_read) begin
			res_q <= rd_res;
		end else if (acc_byte && (over || chk_byte)) begin
			res_q <= fin_res;
		end else if (state_q == S_MRD) begin
			res_q.read_data <= mat_hit_q ? mat_rd_q : 8'd0;
		end
		if (acc) begin
			motion_q <= '0;
		end else if ((state_q == S_WR) && (job_q == JOB_BALL)) begin
			motion_q <= {pay_rd_q, motion_q[31:8]};
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.result_kind    = out_q.result_kind;
	assign rsp.frame_status   = out_q.frame_status;
	assign rsp.source_device  = out_q.source_device;
	assign rsp.frame_type     = out_q.frame_type;
	assign rsp.frame_length   = out_q.frame_length;
	assign rsp.matrix_updated = out_q.matrix_updated;
	assign rsp.motion_valid   = out_q.motion_valid;
	assign rsp.move_x         = out_q.move_x;
	assign rsp.move_y         = out_q.move_y;
	assign rsp.read_data      = out_q.read_data;

	a_hunt_count: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (cnt_q == '0))
		else $error("byte count not cleared while hunting");

	a_copy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RD) || (state_q == S_WR)) |-> (i_q < n_q))
		else $error("payload step beyond its count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (cnt_q <= CNT_W'(HDR_BYTES + MAX_PAYLOAD_BYTES)))
		else $error("frame byte count beyond the longest frame");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EMIT) && out_valid_q && !rsp.ready) |=> (state_q == S_EMIT))
		else $error("result overwrote a held item");

	a_ball_job: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RD) && (job_q == JOB_BALL)) |-> (n_q == COPY_W'(BALL_BYTES)))
		else $error("trackball read with a wrong byte count");

endmodule

// ===== sim/kpd_frame_checker.sv =====
// Scoreboard for the key packet deframer: watches both channels, keeps its own copy of
// the frame parser and key matrix, and compares every result item with its prediction.
// Depends on kpd_pkg, kpd_req_if and kpd_rsp_if.

module kpd_frame_checker
	import kpd_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = 32,
	parameter int LEFT_COLUMNS      = 8,
	parameter int RIGHT_COLUMNS     = 8,
	parameter int MATRIX_COLUMNS    = 16
) (
	input  logic clk,
	input  logic arst_n,
	kpd_req_if   req,
	kpd_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);

	logic        framing;
	int          pos;
	logic [7:0]  chk_acc;
	logic [7:0]  hdr_dev;
	logic [7:0]  hdr_kind;
	logic [7:0]  hdr_len;
	logic [7:0]  payload_mem [MAX_PAYLOAD_BYTES];
	logic [7:0]  key_cols [MATRIX_COLUMNS];
	kpd_result_t expected_results [$];

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		kpd_result_t r;
		int          base;
		int          span;
		r = '0;
		if (!framing) begin
			if (b == START_MARK) begin
				framing = 1'b1;
				pos = 1;
				chk_acc = START_MARK;
			end
			return;
		end
		r.result_kind = KIND_FRAME;
		if (pos < HDR_BYTES) begin
			case (pos)
				1: hdr_dev = b;
				3: hdr_kind = b;
				4: hdr_len = b;
				default: ;
			endcase
			chk_acc ^= b;
			pos++;
			if (pos == HDR_BYTES && hdr_len > MAX_PAYLOAD_BYTES) begin
				framing = 1'b0;
				pos = 0;
				r.frame_status = ST_BAD_LENGTH;
				r.source_device = hdr_dev;
				r.frame_type = hdr_kind;
				r.frame_length = hdr_len;
				expected_results.push_back(r);
			end
			return;
		end
		if (pos < HDR_BYTES + hdr_len) begin
			if (pos - HDR_BYTES < MAX_PAYLOAD_BYTES) begin
				payload_mem[pos - HDR_BYTES] = b;
			end
			chk_acc ^= b;
			pos++;
			return;
		end
		r.frame_status = ST_OK;
		r.source_device = hdr_dev;
		r.frame_type = hdr_kind;
		r.frame_length = hdr_len;
		if (chk_acc != b) begin
			r.frame_status = ST_BAD_CHECKSUM;
		end else if (hdr_kind == TYPE_KEY) begin
			if (hdr_dev == DEV_LEFT || hdr_dev == DEV_RIGHT) begin
				base = (hdr_dev == DEV_LEFT) ? 0 : LEFT_COLUMNS;
				span = (hdr_dev == DEV_LEFT) ? LEFT_COLUMNS : RIGHT_COLUMNS;
				if (hdr_len < span) begin
					span = hdr_len;
				end
				for (int i = 0; i < span; i++) begin
					if (base + i < MATRIX_COLUMNS && i < MAX_PAYLOAD_BYTES) begin
						key_cols[base + i] = payload_mem[i];
					end
				end
				r.matrix_updated = 1'b1;
			end
		end else if (hdr_kind == TYPE_BALL) begin
			if (hdr_len >= BALL_BYTES) begin
				r.motion_valid = 1'b1;
				r.move_x = {payload_mem[1], payload_mem[0]};
				r.move_y = {payload_mem[3], payload_mem[2]};
			end
		end else if (hdr_kind != TYPE_SYSTEM && hdr_kind != TYPE_BATTERY) begin
			r.frame_status = ST_BAD_TYPE;
		end
		framing = 1'b0;
		pos = 0;
		expected_results.push_back(r);
	endtask

	task automatic predict_column_read(input logic [3:0] idx);
		kpd_result_t r;
		r = '0;
		r.result_kind = KIND_READ;
		r.read_data = (idx < MATRIX_COLUMNS) ? key_cols[idx] : 8'h00;
		expected_results.push_back(r);
	endtask

	task automatic compare_result();
		kpd_result_t w;
		if (expected_results.size() == 0) begin
			report_mismatch("result item with nothing expected");
			return;
		end
		w = expected_results.pop_front();
		check_field("result_kind", rsp.result_kind, w.result_kind);
		check_field("frame_status", rsp.frame_status, w.frame_status);
		check_field("source_device", rsp.source_device, w.source_device);
		check_field("frame_type", rsp.frame_type, w.frame_type);
		check_field("frame_length", rsp.frame_length, w.frame_length);
		check_field("matrix_updated", rsp.matrix_updated, w.matrix_updated);
		check_field("motion_valid", rsp.motion_valid, w.motion_valid);
		check_field("move_x", rsp.move_x, w.move_x);
		check_field("move_y", rsp.move_y, w.move_y);
		check_field("read_data", rsp.read_data, w.read_data);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			framing = 1'b0;
			pos = 0;
			chk_acc = '0;
			hdr_dev = '0;
			hdr_kind = '0;
			hdr_len = '0;
			for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) begin
				payload_mem[i] = '0;
			end
			for (int i = 0; i < MATRIX_COLUMNS; i++) begin
				key_cols[i] = '0;
			end
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				compare_result();
			end
			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				if (req.opcode == OP_READ) begin
					predict_column_read(req.read_index);
				end else begin
					deframe_byte(req.rx_byte);
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

// ===== sim/key_packet_deframer_unit_test.sv =====
// Top of the key packet deframer testbench: clock, reset, radio byte and column read
// stimulus with random sender gaps and receiver stalls, and the final verdict.
// Depends on kpd_pkg, both channel interfaces, the block and kpd_frame_checker.

module key_packet_deframer_unit_test
	import kpd_pkg::*;
();

	localparam int MAX_LEN     = 32;
	localparam int CYCLE_LIMIT = 300000;

	logic       clk = 1'b0;
	logic       arst_n;
	int         fail_count;
	int         pending;
	int         cycles = 0;
	int         items_sent = 0;
	int         burst_left = 0;
	int         gap_max = 0;
	bit         mix_reads = 1'b0;
	int         stall_style = 0;
	int         style_left = 0;
	int         stall_tick = 0;
	logic [7:0] body [MAX_LEN];

	kpd_req_if req_ch ();
	kpd_rsp_if rsp_ch ();

	key_packet_deframer_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	kpd_frame_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// The receiver switches at random among always ready, coin toss, long stalls and a fixed rhythm.
	always @(negedge clk) begin
		if (style_left == 0) begin
			stall_style = $urandom_range(0, 3);
			style_left = $urandom_range(64, 256);
		end
		style_left--;
		stall_tick++;
		case (stall_style)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= $urandom_range(0, 1);
			2: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
			default: rsp_ch.ready <= (stall_tick % 5) != 0;
		endcase
	end

	task automatic send_item(input logic op, input logic [7:0] b, input logic [3:0] idx);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.rx_byte <= b;
		req_ch.read_index <= idx;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_read(input logic [3:0] idx);
		send_item(OP_READ, 8'($urandom_range(0, 255)), idx);
	endtask

	task automatic send_byte(input logic [7:0] b);
		if (mix_reads && $urandom_range(0, 15) == 0) begin
			send_read(4'($urandom_range(0, 15)));
		end
		send_item(OP_BYTE, b, 4'($urandom_range(0, 15)));
	endtask

	task automatic send_frame(input logic [7:0] dev, input logic [7:0] kind,
		input logic [7:0] len, input bit bad_sum);
		logic [7:0] ver;
		logic [7:0] sum;
		ver = 8'($urandom_range(0, 255));
		sum = START_MARK ^ dev ^ ver ^ kind ^ len;
		send_byte(START_MARK);
		send_byte(dev);
		send_byte(ver);
		send_byte(kind);
		send_byte(len);
		if (len > MAX_LEN) begin
			return;
		end
		for (int i = 0; i < len; i++) begin
			send_byte(body[i]);
			sum ^= body[i];
		end
		if (bad_sum) begin
			sum ^= 8'($urandom_range(1, 255));
		end
		send_byte(sum);
	endtask

	task automatic fill_body_random();
		for (int i = 0; i < MAX_LEN; i++) begin
			body[i] = 8'($urandom_range(0, 255));
		end
	endtask

	initial begin
		int         pick;
		logic [7:0] dev;
		logic [7:0] kind;
		logic [7:0] len;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_BYTE;
		req_ch.rx_byte = '0;
		req_ch.read_index = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		gap_max = 3;
		send_read(4'd0);
		send_read(4'd15);
		send_byte(8'h00);
		send_byte(8'hFF);
		for (int i = 0; i < MAX_LEN; i++) begin
			body[i] = (i % 2 == 0) ? 8'hFF : 8'(i * 37);
		end
		send_frame(DEV_LEFT, TYPE_KEY, 8'd8, 1'b0);
		send_frame(DEV_RIGHT, TYPE_KEY, 8'd10, 1'b0);
		send_frame(8'h03, TYPE_KEY, 8'd2, 1'b0);
		send_frame(DEV_LEFT, TYPE_KEY, 8'd0, 1'b0);
		body[0] = 8'h00;
		body[1] = 8'h80;
		body[2] = 8'hFF;
		body[3] = 8'h7F;
		send_frame(DEV_RIGHT, TYPE_BALL, 8'd4, 1'b0);
		send_frame(DEV_LEFT, TYPE_BALL, 8'd3, 1'b0);
		body[0] = START_MARK;
		body[1] = START_MARK;
		send_frame(DEV_LEFT, TYPE_SYSTEM, 8'd2, 1'b0);
		send_frame(DEV_RIGHT, TYPE_BATTERY, 8'd0, 1'b0);
		send_frame(8'hFF, 8'h00, 8'd1, 1'b0);
		send_frame(8'h00, 8'hFF, 8'd1, 1'b0);
		send_frame(DEV_LEFT, TYPE_KEY, 8'd4, 1'b1);
		send_frame(DEV_LEFT, TYPE_BALL, 8'd33, 1'b0);
		send_frame(DEV_RIGHT, TYPE_KEY, 8'd255, 1'b0);
		fill_body_random();
		send_frame(DEV_LEFT, TYPE_BALL, 8'd32, 1'b0);
		send_read(4'd8);
		send_read(4'd15);
		send_read(4'd7);

		// Mostly well-formed frames with random content; some noise, reads and torn frames.
		mix_reads = 1'b1;
		while (items_sent < 450) begin
			if (items_sent % 40 < 4) begin
				case ($urandom_range(0, 3))
					0: gap_max = 0;
					1: gap_max = 1;
					2: gap_max = 3;
					default: gap_max = 8;
				endcase
			end
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 18) begin
				repeat ($urandom_range(1, 3)) send_read(4'($urandom_range(0, 15)));
			end else if (pick < 22) begin
				send_byte(START_MARK);
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
			end else begin
				pick = $urandom_range(0, 99);
				dev = (pick < 45) ? DEV_LEFT : (pick < 90) ? DEV_RIGHT :
					8'($urandom_range(0, 255));
				pick = $urandom_range(0, 99);
				kind = (pick < 35) ? TYPE_KEY : (pick < 60) ? TYPE_BALL :
					(pick < 70) ? TYPE_SYSTEM : (pick < 80) ? TYPE_BATTERY :
					8'($urandom_range(0, 255));
				pick = $urandom_range(0, 99);
				len = (pick < 70) ? 8'($urandom_range(0, 10)) :
					(pick < 92) ? 8'($urandom_range(11, MAX_LEN)) :
					8'($urandom_range(MAX_LEN + 1, 255));
				fill_body_random();
				send_frame(dev, kind, len, $urandom_range(0, 9) == 0);
			end
		end
		req_ch.valid <= 1'b0;

		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
